@@ rtl/miex_pkg.sv @@
// Shared types and constants for the MIPS I integer execute unit.
`timescale 1ns / 1ps
package miex_pkg;
   localparam int RegWidth = 32;
   localparam int RegDepth = 32;

   localparam logic [2:0] EXC_NONE     = 3'd0;
   localparam logic [2:0] EXC_OVERFLOW = 3'd1;
   localparam logic [2:0] EXC_RESERVED = 3'd2;
   localparam logic [2:0] EXC_COP      = 3'd3;
   localparam logic [2:0] EXC_SYSCALL  = 3'd4;
   localparam logic [2:0] EXC_BREAK    = 3'd5;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_REGIMM  = 6'd1;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_SLTIU   = 6'd11;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_COP0    = 6'd16;
   localparam logic [5:0] OP_COP1    = 6'd17;
   localparam logic [5:0] OP_COP2    = 6'd18;
   localparam logic [5:0] OP_COP3    = 6'd19;
   localparam logic [5:0] OP_LB      = 6'd32;
   localparam logic [5:0] OP_LH      = 6'd33;
   localparam logic [5:0] OP_LWL     = 6'd34;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_LBU     = 6'd36;
   localparam logic [5:0] OP_LHU     = 6'd37;
   localparam logic [5:0] OP_LWR     = 6'd38;
   localparam logic [5:0] OP_SB      = 6'd40;
   localparam logic [5:0] OP_SH      = 6'd41;
   localparam logic [5:0] OP_SWL     = 6'd42;
   localparam logic [5:0] OP_SW      = 6'd43;
   localparam logic [5:0] OP_SWR     = 6'd46;
   localparam logic [5:0] OP_LWC0    = 6'd48;
   localparam logic [5:0] OP_LWC1    = 6'd49;
   localparam logic [5:0] OP_LWC2    = 6'd50;
   localparam logic [5:0] OP_LWC3    = 6'd51;
   localparam logic [5:0] OP_SWC0    = 6'd56;
   localparam logic [5:0] OP_SWC1    = 6'd57;
   localparam logic [5:0] OP_SWC2    = 6'd58;
   localparam logic [5:0] OP_SWC3    = 6'd59;

   localparam logic [4:0] RT_BLTZ    = 5'd0;
   localparam logic [4:0] RT_BGEZ    = 5'd1;
   localparam logic [4:0] RT_BLTZAL  = 5'd16;
   localparam logic [4:0] RT_BGEZAL  = 5'd17;

   localparam logic [5:0] FN_SLL     = 6'd0;
   localparam logic [5:0] FN_SRL     = 6'd2;
   localparam logic [5:0] FN_SRA     = 6'd3;
   localparam logic [5:0] FN_SLLV    = 6'd4;
   localparam logic [5:0] FN_SRLV    = 6'd6;
   localparam logic [5:0] FN_SRAV    = 6'd7;
   localparam logic [5:0] FN_JR      = 6'd8;
   localparam logic [5:0] FN_JALR    = 6'd9;
   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_BREAK   = 6'd13;
   localparam logic [5:0] FN_MFHI    = 6'd16;
   localparam logic [5:0] FN_MTHI    = 6'd17;
   localparam logic [5:0] FN_MFLO    = 6'd18;
   localparam logic [5:0] FN_MTLO    = 6'd19;
   localparam logic [5:0] FN_MULT    = 6'd24;
   localparam logic [5:0] FN_MULTU   = 6'd25;
   localparam logic [5:0] FN_DIV     = 6'd26;
   localparam logic [5:0] FN_DIVU    = 6'd27;
   localparam logic [5:0] FN_ADD     = 6'd32;
   localparam logic [5:0] FN_ADDU    = 6'd33;
   localparam logic [5:0] FN_SUB     = 6'd34;
   localparam logic [5:0] FN_SUBU    = 6'd35;
   localparam logic [5:0] FN_AND     = 6'd36;
   localparam logic [5:0] FN_OR      = 6'd37;
   localparam logic [5:0] FN_XOR     = 6'd38;
   localparam logic [5:0] FN_NOR     = 6'd39;
   localparam logic [5:0] FN_SLT     = 6'd42;
   localparam logic [5:0] FN_SLTU    = 6'd43;

   typedef struct packed {
      logic capture;
      logic exec;
      logic iter;
      logic fix;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic long_op;
   } status_type;
endpackage

@@ rtl/miex_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface miex_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   logic [31:0] instr_address;
   modport source(output valid, instr_word, instr_address, input ready);
   modport sink(input valid, instr_word, instr_address, output ready);
endinterface

interface miex_rsp_if;
   logic        valid;
   logic        ready;
   logic        wb_enable;
   logic [4:0]  wb_reg;
   logic [31:0] wb_value;
   logic        branch_taken;
   logic [31:0] branch_target;
   logic [2:0]  exception_code;
   logic [1:0]  cop_number;
   logic        memory_request;
   modport source(output valid, wb_enable, wb_reg, wb_value, branch_taken, branch_target,
                  exception_code, cop_number, memory_request, input ready);
   modport sink(input valid, wb_enable, wb_reg, wb_value, branch_taken, branch_target,
                exception_code, cop_number, memory_request, output ready);
endinterface

@@ rtl/mips_integer_execute_unit_core.sv @@
// Top level of the MIPS I integer execute unit.
// Executes one MIPS I instruction per request transaction against a 32 x 32
// register file (r0 reads zero) and HI/LO, and returns one response transaction
// with the register write, branch redirect, exception and memory-access flag.
// One instruction is in flight at a time: after a request is accepted the unit
// steps through register-file read, execute and commit, and the response is
// registered at commit; the next request is accepted once it is back in idle.
// MULT/MULTU and DIV/DIVU that enter the one-bit-per-cycle loop add 32 iterations
// and a sign fix between execute and commit.
// A divide by zero and the signed divide overflow take the short path.
// The response register lets the next request be accepted while a response waits;
// that instruction then holds in its commit cycle until the response is taken.
`timescale 1ns / 1ps
module mips_integer_execute_unit_core (
   input logic       clock,
   input logic       reset,
   miex_req_if.sink  req_chan,
   miex_rsp_if.source rsp_chan
);
   miex_pkg::cmd_type    cmd;
   miex_pkg::status_type status;

   miex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   miex_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_instr_word     (req_chan.instr_word),
      .req_instr_address  (req_chan.instr_address),
      .cmd                (cmd),
      .status             (status),
      .rsp_wb_enable      (rsp_chan.wb_enable),
      .rsp_wb_reg         (rsp_chan.wb_reg),
      .rsp_wb_value       (rsp_chan.wb_value),
      .rsp_branch_taken   (rsp_chan.branch_taken),
      .rsp_branch_target  (rsp_chan.branch_target),
      .rsp_exception_code (rsp_chan.exception_code),
      .rsp_cop_number     (rsp_chan.cop_number),
      .rsp_memory_request (rsp_chan.memory_request)
   );
endmodule

@@ rtl/miex_ram.sv @@
// Generic RAM, one write port and two registered read ports.
`timescale 1ns / 1ps
module miex_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

@@ rtl/miex_ctrl.sv @@
// Sequencing state machine for the execute unit.
`timescale 1ns / 1ps
module miex_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  miex_pkg::status_type status,
   output miex_pkg::cmd_type   cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_ITER = 3'd3;
   localparam logic [2:0] ST_FIX  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [4:0] count_ff, count_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            cmd.exec = 1'b1;
            count_in = '0;
            state_in = status.long_op ? ST_ITER : ST_DONE;
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            count_in = count_ff + 5'd1;
            if (count_ff == 5'd31) state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end
endmodule

@@ rtl/miex_dp.sv @@
// Datapath: register file, ALU, branch logic, HI/LO and iterative multiply/divide.
`timescale 1ns / 1ps
module miex_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          req_instr_word,
   input  logic [31:0]          req_instr_address,
   input  miex_pkg::cmd_type    cmd,
   output miex_pkg::status_type status,
   output logic                 rsp_wb_enable,
   output logic [4:0]           rsp_wb_reg,
   output logic [31:0]          rsp_wb_value,
   output logic                 rsp_branch_taken,
   output logic [31:0]          rsp_branch_target,
   output logic [2:0]           rsp_exception_code,
   output logic [1:0]           rsp_cop_number,
   output logic                 rsp_memory_request
);
   logic [31:0] instr_ff, addr_ff;
   logic [31:0] valid_bits_ff;
   logic        va_ff, vb_ff;
   logic [31:0] ram_a, ram_b, a, b;
   logic [63:0] hilo_ff, hilo_in;
   logic [31:0] hi_acc_ff, lo_acc_ff, opnd_ff;
   logic        is_div_ff, neg_q_ff, neg_r_ff;

   logic        wen_ff, taken_ff, mem_ff;
   logic [4:0]  wreg_ff;
   logic [31:0] wval_ff, tgt_ff;
   logic [2:0]  exc_ff;
   logic [1:0]  cop_ff;

   logic        wen, taken, mem, long_op, div_op, neg_q, neg_r;
   logic [4:0]  wreg;
   logic [31:0] wval, tgt, ma, mb;
   logic [2:0]  exc;
   logic [1:0]  cop;
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa;
   logic [31:0] simm, imm, btgt, link, sum, dif, simm_sum;
   logic        commit_we;

   miex_ram #(.WIDTH(miex_pkg::RegWidth), .DEPTH(miex_pkg::RegDepth)) u_regs (
      .clock     (clock),
      .wr_en     (commit_we),
      .wr_addr   (wreg_ff),
      .wr_data   (wval_ff),
      .rd_addr_a (rs),
      .rd_data_a (ram_a),
      .rd_addr_b (rt),
      .rd_data_b (ram_b)
   );

   assign commit_we = cmd.commit && wen_ff;
   assign a = va_ff ? ram_a : '0;
   assign b = vb_ff ? ram_b : '0;

   assign op   = instr_ff[31:26];
   assign rs   = instr_ff[25:21];
   assign rt   = instr_ff[20:16];
   assign rd   = instr_ff[15:11];
   assign sa   = instr_ff[10:6];
   assign fn   = instr_ff[5:0];
   assign imm  = {16'd0, instr_ff[15:0]};
   assign simm = {{16{instr_ff[15]}}, instr_ff[15:0]};
   assign btgt = addr_ff + 32'd4 + {simm[29:0], 2'b00};
   assign link = addr_ff + 32'd8;
   assign sum  = a + b;
   assign dif  = a - b;
   assign simm_sum = a + simm;
   assign ma   = a[31] ? -a : a;
   assign mb   = b[31] ? -b : b;

   always_comb begin
      wen = 1'b0; wreg = '0; wval = '0; taken = 1'b0; tgt = '0;
      exc = miex_pkg::EXC_NONE; cop = '0; mem = 1'b0;
      long_op = 1'b0; div_op = 1'b0; neg_q = 1'b0; neg_r = 1'b0;
      hilo_in = hilo_ff;
      unique case (op)
         miex_pkg::OP_SPECIAL: begin
            unique case (fn)
               miex_pkg::FN_SLL:  begin wen = 1'b1; wreg = rd; wval = b << sa; end
               miex_pkg::FN_SRL:  begin wen = 1'b1; wreg = rd; wval = b >> sa; end
               miex_pkg::FN_SRA:  begin wen = 1'b1; wreg = rd; wval = $signed(b) >>> sa; end
               miex_pkg::FN_SLLV: begin wen = 1'b1; wreg = rd; wval = b << a[4:0]; end
               miex_pkg::FN_SRLV: begin wen = 1'b1; wreg = rd; wval = b >> a[4:0]; end
               miex_pkg::FN_SRAV: begin
                  wen = 1'b1; wreg = rd; wval = $signed(b) >>> a[4:0];
               end
               miex_pkg::FN_JR: begin taken = 1'b1; tgt = {a[31:2], 2'b00}; end
               miex_pkg::FN_JALR: begin
                  taken = 1'b1; tgt = {a[31:2], 2'b00};
                  wen = 1'b1; wreg = rd; wval = link;
               end
               miex_pkg::FN_SYSCALL: exc = miex_pkg::EXC_SYSCALL;
               miex_pkg::FN_BREAK:   exc = miex_pkg::EXC_BREAK;
               miex_pkg::FN_MFHI: begin wen = 1'b1; wreg = rd; wval = hilo_ff[63:32]; end
               miex_pkg::FN_MTHI: hilo_in = {a, hilo_ff[31:0]};
               miex_pkg::FN_MFLO: begin wen = 1'b1; wreg = rd; wval = hilo_ff[31:0]; end
               miex_pkg::FN_MTLO: hilo_in = {hilo_ff[63:32], a};
               miex_pkg::FN_MULT: begin long_op = 1'b1; neg_q = a[31] ^ b[31]; end
               miex_pkg::FN_MULTU: long_op = 1'b1;
               miex_pkg::FN_DIV: begin
                  if (b == '0) begin
                     hilo_in = {a, (a[31] ? 32'd1 : 32'hFFFF_FFFF)};
                  end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                     hilo_in = {32'd0, 32'h8000_0000};
                  end else begin
                     long_op = 1'b1; div_op = 1'b1;
                     neg_q = a[31] ^ b[31]; neg_r = a[31];
                  end
               end
               miex_pkg::FN_DIVU: begin
                  if (b == '0) hilo_in = {a, 32'hFFFF_FFFF};
                  else begin long_op = 1'b1; div_op = 1'b1; end
               end
               miex_pkg::FN_ADD: begin
                  if (~(a[31] ^ b[31]) & (a[31] ^ sum[31])) exc = miex_pkg::EXC_OVERFLOW;
                  else begin wen = 1'b1; wreg = rd; wval = sum; end
               end
               miex_pkg::FN_ADDU: begin wen = 1'b1; wreg = rd; wval = sum; end
               miex_pkg::FN_SUB: begin
                  if ((a[31] ^ b[31]) & (a[31] ^ dif[31])) exc = miex_pkg::EXC_OVERFLOW;
                  else begin wen = 1'b1; wreg = rd; wval = dif; end
               end
               miex_pkg::FN_SUBU: begin wen = 1'b1; wreg = rd; wval = dif; end
               miex_pkg::FN_AND:  begin wen = 1'b1; wreg = rd; wval = a & b; end
               miex_pkg::FN_OR:   begin wen = 1'b1; wreg = rd; wval = a | b; end
               miex_pkg::FN_XOR:  begin wen = 1'b1; wreg = rd; wval = a ^ b; end
               miex_pkg::FN_NOR:  begin wen = 1'b1; wreg = rd; wval = ~(a | b); end
               miex_pkg::FN_SLT: begin
                  wen = 1'b1; wreg = rd; wval = {31'd0, $signed(a) < $signed(b)};
               end
               miex_pkg::FN_SLTU: begin wen = 1'b1; wreg = rd; wval = {31'd0, a < b}; end
               default: exc = miex_pkg::EXC_RESERVED;
            endcase
         end
         miex_pkg::OP_REGIMM: begin
            if (rt == miex_pkg::RT_BLTZ || rt == miex_pkg::RT_BGEZ ||
                rt == miex_pkg::RT_BLTZAL || rt == miex_pkg::RT_BGEZAL) begin
               taken = a[31] ^ rt[0];
               tgt   = btgt;
               if (rt[4]) begin wen = 1'b1; wreg = 5'd31; wval = link; end
            end else begin
               exc = miex_pkg::EXC_RESERVED;
            end
         end
         miex_pkg::OP_J: begin
            taken = 1'b1; tgt = {addr_ff[31:28], instr_ff[25:0], 2'b00};
         end
         miex_pkg::OP_JAL: begin
            taken = 1'b1; tgt = {addr_ff[31:28], instr_ff[25:0], 2'b00};
            wen = 1'b1; wreg = 5'd31; wval = link;
         end
         miex_pkg::OP_BEQ:  begin taken = (a == b); tgt = btgt; end
         miex_pkg::OP_BNE:  begin taken = (a != b); tgt = btgt; end
         miex_pkg::OP_BLEZ: begin taken = a[31] || (a == '0); tgt = btgt; end
         miex_pkg::OP_BGTZ: begin taken = !a[31] && (a != '0); tgt = btgt; end
         miex_pkg::OP_ADDI: begin
            if (~(a[31] ^ simm[31]) & (a[31] ^ simm_sum[31])) exc = miex_pkg::EXC_OVERFLOW;
            else begin wen = 1'b1; wreg = rt; wval = simm_sum; end
         end
         miex_pkg::OP_ADDIU: begin wen = 1'b1; wreg = rt; wval = simm_sum; end
         miex_pkg::OP_SLTI: begin
            wen = 1'b1; wreg = rt; wval = {31'd0, $signed(a) < $signed(simm)};
         end
         miex_pkg::OP_SLTIU: begin wen = 1'b1; wreg = rt; wval = {31'd0, a < simm}; end
         miex_pkg::OP_ANDI: begin wen = 1'b1; wreg = rt; wval = a & imm; end
         miex_pkg::OP_ORI:  begin wen = 1'b1; wreg = rt; wval = a | imm; end
         miex_pkg::OP_XORI: begin wen = 1'b1; wreg = rt; wval = a ^ imm; end
         miex_pkg::OP_LUI:  begin wen = 1'b1; wreg = rt; wval = {instr_ff[15:0], 16'd0}; end
         miex_pkg::OP_COP0, miex_pkg::OP_COP1, miex_pkg::OP_COP2, miex_pkg::OP_COP3,
         miex_pkg::OP_LWC0, miex_pkg::OP_LWC1, miex_pkg::OP_LWC2, miex_pkg::OP_LWC3,
         miex_pkg::OP_SWC0, miex_pkg::OP_SWC1, miex_pkg::OP_SWC2, miex_pkg::OP_SWC3: begin
            exc = miex_pkg::EXC_COP; cop = op[1:0];
         end
         miex_pkg::OP_LB, miex_pkg::OP_LH, miex_pkg::OP_LWL, miex_pkg::OP_LW,
         miex_pkg::OP_LBU, miex_pkg::OP_LHU, miex_pkg::OP_LWR, miex_pkg::OP_SB,
         miex_pkg::OP_SH, miex_pkg::OP_SWL, miex_pkg::OP_SW, miex_pkg::OP_SWR: mem = 1'b1;
         default: exc = miex_pkg::EXC_RESERVED;
      endcase
      if (!taken) tgt = '0;
      if (!wen || wreg == 5'd0) begin wen = 1'b0; wreg = '0; wval = '0; end
   end

   assign status.long_op = long_op;

   // shift-add multiply / restoring divide on magnitudes
   logic [32:0] madd, dsub;
   logic [63:0] prod_fix;
   assign madd = {1'b0, hi_acc_ff} + (lo_acc_ff[0] ? {1'b0, opnd_ff} : 33'd0);
   assign dsub = {hi_acc_ff, lo_acc_ff[31]} - {1'b0, opnd_ff};
   assign prod_fix = neg_q_ff ? -{hi_acc_ff, lo_acc_ff} : {hi_acc_ff, lo_acc_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         instr_ff <= req_instr_word;
         addr_ff  <= req_instr_address;
         va_ff    <= valid_bits_ff[req_instr_word[25:21]];
         vb_ff    <= valid_bits_ff[req_instr_word[20:16]];
      end
      if (cmd.exec) begin
         wen_ff <= wen; wreg_ff <= wreg; wval_ff <= wval;
         taken_ff <= taken; tgt_ff <= tgt; exc_ff <= exc; cop_ff <= cop; mem_ff <= mem;
         is_div_ff <= div_op; neg_q_ff <= neg_q; neg_r_ff <= neg_r;
         hi_acc_ff <= '0;
         if (fn == miex_pkg::FN_MULTU || fn == miex_pkg::FN_DIVU) begin
            lo_acc_ff <= div_op ? a : b;
            opnd_ff   <= div_op ? b : a;
         end else begin
            lo_acc_ff <= div_op ? ma : mb;
            opnd_ff   <= div_op ? mb : ma;
         end
      end
      if (cmd.iter) begin
         if (is_div_ff) begin
            hi_acc_ff <= dsub[32] ? {hi_acc_ff[30:0], lo_acc_ff[31]} : dsub[31:0];
            lo_acc_ff <= {lo_acc_ff[30:0], ~dsub[32]};
         end else begin
            hi_acc_ff <= madd[32:1];
            lo_acc_ff <= {madd[0], lo_acc_ff[31:1]};
         end
      end
      if (cmd.commit) begin
         rsp_wb_enable      <= wen_ff;
         rsp_wb_reg         <= wreg_ff;
         rsp_wb_value       <= wval_ff;
         rsp_branch_taken   <= taken_ff;
         rsp_branch_target  <= tgt_ff;
         rsp_exception_code <= exc_ff;
         rsp_cop_number     <= cop_ff;
         rsp_memory_request <= mem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hilo_ff       <= '0;
         valid_bits_ff <= '0;
      end else begin
         if (cmd.exec) hilo_ff <= hilo_in;
         if (cmd.fix) begin
            if (is_div_ff)
               hilo_ff <= {(neg_r_ff ? -hi_acc_ff : hi_acc_ff),
                           (neg_q_ff ? -lo_acc_ff : lo_acc_ff)};
            else
               hilo_ff <= prod_fix;
         end
         if (commit_we) valid_bits_ff[wreg_ff] <= 1'b1;
      end
   end
endmodule
